FILE: hw/rtl/cfp_pkg.sv
package cfp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'd255;
    localparam logic [7:0] LIMIT_RESET = 8'd13;

    // Frame position, one-hot.
    typedef enum logic [5:0] {
        PH_HUNT  = 6'b000001,
        PH_CMD   = 6'b000010,
        PH_HIGH  = 6'b000100,
        PH_LOW   = 6'b001000,
        PH_SEQ   = 6'b010000,
        PH_CHECK = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [6:0]  sequence_res;
        logic [13:0] value;
        logic [6:0]  command;
    } result_t;

endpackage

FILE: hw/rtl/cfp_frame_fsm.sv
module cfp_frame_fsm (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       command_limit,
    output logic             match,
    output cfp_pkg::result_t result
);

    cfp_pkg::phase_t phase_reg, phase_next;
    logic [6:0] command_reg, command_next;
    logic [6:0] high_reg, high_next;
    logic [6:0] low_reg, low_next;
    logic [6:0] sequence_reg, sequence_next;
    logic [7:0] check_sum;
    logic       cmd_ok;

    // A limit above 128 acts as 128, so the top bit of the byte must be clear too.
    assign cmd_ok    = (rx_byte < command_limit) && !rx_byte[7];
    assign check_sum = {1'b0, low_reg} + {1'b0, command_reg};
    assign match     = (phase_reg == cfp_pkg::PH_CHECK) && (check_sum == rx_byte);

    assign result.command      = command_reg;
    assign result.value        = {high_reg, low_reg};
    assign result.sequence_res = sequence_reg;

    always_comb begin
        phase_next    = phase_reg;
        command_next  = command_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        sequence_next = sequence_reg;
        if (step) begin
            phase_next = cfp_pkg::PH_HUNT;
            case (phase_reg)
                cfp_pkg::PH_HUNT: begin
                    if (rx_byte == cfp_pkg::SYNC_BYTE) begin
                        phase_next = cfp_pkg::PH_CMD;
                    end
                end
                cfp_pkg::PH_CMD: begin
                    if (cmd_ok) begin
                        command_next = rx_byte[6:0];
                        phase_next   = cfp_pkg::PH_HIGH;
                    end
                end
                cfp_pkg::PH_HIGH: begin
                    if (!rx_byte[7]) begin
                        high_next  = rx_byte[6:0];
                        phase_next = cfp_pkg::PH_LOW;
                    end
                end
                cfp_pkg::PH_LOW: begin
                    if (!rx_byte[7]) begin
                        low_next   = rx_byte[6:0];
                        phase_next = cfp_pkg::PH_SEQ;
                    end
                end
                cfp_pkg::PH_SEQ: begin
                    if (!rx_byte[7]) begin
                        sequence_next = rx_byte[6:0];
                        phase_next    = cfp_pkg::PH_CHECK;
                    end
                end
                default: begin
                    phase_next = cfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= cfp_pkg::PH_HUNT;
            command_reg  <= '0;
            high_reg     <= '0;
            low_reg      <= '0;
            sequence_reg <= '0;
        end else begin
            phase_reg    <= phase_next;
            command_reg  <= command_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            sequence_reg <= sequence_next;
        end
    end

endmodule

FILE: hw/rtl/command_frame_parser.sv
// Command frame parser.
// The slave channel carries one received serial byte per request. The parser
// hunts for a six-byte frame: a sync byte of 255, a command byte below the
// configured limit, high and low 7-bit value bytes, a 7-bit sequence byte and
// a checksum byte equal to the low value byte plus the command. A frame with a
// good checksum produces one request on the master channel carrying the
// command, the 14-bit value and the sequence number; anything else produces
// nothing, and any out-of-range byte sends the parser back to sync hunting.
// Throughput is one byte per cycle unless a result waits on a stalled receiver.
// A byte is captured in an input register for the frame state machine, and a
// result is registered in the output register that drives m_tvalid. The user
// must write the limit through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this. Reset clears the frame state, empties
// both registers and sets the limit to 13. When the receiver stalls, the result
// waits in the output register; bytes that produce no result keep flowing, and
// s_tready drops only when a second result would need the occupied register.
module command_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // command_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata        // command[6:0], value[20:7], sequence_res[27:21]
);

    logic [7:0]       limit_reg;
    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg, out_valid_next;
    cfp_pkg::result_t out_data_reg;
    logic             out_free;
    logic             in_adv;
    logic             fsm_match;
    cfp_pkg::result_t fsm_result;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;
    // A byte that yields no result never waits on the receiver.
    assign in_adv   = in_valid_reg && (out_free || !fsm_match);
    assign s_tready = !in_valid_reg || in_adv;

    cfp_frame_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (in_adv),
        .rx_byte       (in_byte_reg),
        .command_limit (limit_reg),
        .match         (fsm_match),
        .result        (fsm_result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (in_adv) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (in_adv && fsm_match) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= cfp_pkg::LIMIT_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (in_adv && fsm_match) begin
            out_data_reg <= fsm_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};

    // An accepted byte is held in the input register on the next cycle.
    a_accept_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted byte not captured");

    // A byte blocked by a full output register is kept unchanged.
    a_stall_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_adv) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("blocked byte lost");

    // A new result appears only after the state machine matched a checksum.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fsm_match && in_adv))
        else $error("result without matching frame");

endmodule
